>>> design/ssnf_pkg.sv
// Shared types, constants and the segment table of the seven-segment frame formatter.
package ssnf_pkg;

    localparam int DIGITS_DEF = 8;
    localparam int CNT_W      = 4;
    localparam int NUM_W      = 32;
    localparam int FRAME_W    = 16;

    localparam logic [7:0]       SCAN_LIMIT_ADDR = 8'h0B;
    localparam logic [3:0]       DEC_MINUS       = 4'hA;
    localparam logic [7:0]       HEX_MINUS       = 8'h01;
    localparam logic [NUM_W-1:0] RECIP_10        = 32'hCCCCCCCD;

    typedef enum logic [1:0] {
        OP_DEC   = 2'd0,
        OP_HEX   = 2'd1,
        OP_SHIFT = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_HEAD,
        ST_EMIT
    } t_state;

    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'h0: s = 8'h7e;
            4'h1: s = 8'h30;
            4'h2: s = 8'h6d;
            4'h3: s = 8'h79;
            4'h4: s = 8'h33;
            4'h5: s = 8'h5b;
            4'h6: s = 8'h5f;
            4'h7: s = 8'h70;
            4'h8: s = 8'h7f;
            4'h9: s = 8'h7b;
            4'hA: s = 8'h77;
            4'hB: s = 8'h1f;
            4'hC: s = 8'h4e;
            4'hD: s = 8'h3d;
            4'hE: s = 8'h4f;
            4'hF: s = 8'h47;
        endcase
        return s;
    endfunction

endpackage

>>> design/ssnf_if.sv
// Handshake interfaces for the request and frame channels.
interface ssnf_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] number;
    logic [3:0]         nibble;

    modport source (output valid, output op, output number, output nibble, input ready);
    modport sink   (input valid, input op, input number, input nibble, output ready);
endinterface

interface ssnf_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] frame;
    logic        last;
    logic        error;

    modport source (output valid, output frame, output last, output error, input ready);
    modport sink   (input valid, input frame, input last, input error, output ready);
endinterface

>>> design/seven_segment_number_frame_formatter.sv
// Top level: turns numbers and shifted nibbles into runs of 16-bit display frames.
//
// Request channel i_in carries op, number and nibble. Frame channel o_out carries
// frame, last and error. Each request (except a shift-count clear) produces a
// scan-limit frame followed by one frame per digit, the last flagged; a number
// that needs more than DIGITS positions produces one error item instead.
// A request is taken only while the sequencer is idle. Digits are produced one
// per cycle by a single shared digit unit: a 32x32 reciprocal multiply for
// decimal, a 4-bit shift for hex and history. A minus sign counts as one more
// digit position. The sequencer converts the digits, adds any minus sign, then
// loads the scan-limit frame (or the error item) and the digit frames in order.
// Frames sit in an output register, so the next request is accepted while the
// final frame still waits; a stalled receiver holds the frame and pauses the
// sequencer.
// Reset clears the nibble history, the shown count and the output valid.
module seven_segment_number_frame_formatter #(
    parameter int DIGITS = ssnf_pkg::DIGITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ssnf_in_if.sink           i_in,
    ssnf_out_if.source        o_out
);
    import ssnf_pkg::*;

    localparam int IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    t_state                  r_state, n_state;
    t_op                     r_op;
    logic [NUM_W-1:0]        r_hist;
    logic [CNT_W-1:0]        r_shown;
    logic [NUM_W-1:0]        r_mag;
    logic                    r_neg;
    logic [CNT_W-1:0]        r_n;
    logic [CNT_W-1:0]        r_idx;
    logic [7:0]              r_codes [DIGITS];
    logic                    r_out_valid;
    logic [FRAME_W-1:0]      r_frame;
    logic                    r_last;
    logic                    r_err;

    logic                    in_ready;
    logic                    conv_en;
    logic                    sign_en;
    logic                    load_out;
    logic                    out_free;

    logic [2*NUM_W-1:0]      prod;
    logic [NUM_W-1:0]        quot;
    logic [3:0]              q10_lo;
    logic [3:0]              dec_digit;
    logic [7:0]              dig_code;
    logic [NUM_W-1:0]        next_mag;
    logic                    conv_stop;
    logic                    too_long;
    logic                    emit_last;
    logic [NUM_W-1:0]        new_hist;

    // shared digit unit
    assign prod      = r_mag * RECIP_10;
    assign quot      = NUM_W'(prod[2*NUM_W-1:35]);
    assign q10_lo    = {quot[0], 3'b000} + {quot[2:0], 1'b0};
    assign dec_digit = r_mag[3:0] - q10_lo;
    assign dig_code  = (r_op == OP_DEC) ? {4'h0, dec_digit} : seg_code(r_mag[3:0]);
    assign next_mag  = (r_op == OP_DEC) ? quot : {4'h0, r_mag[NUM_W-1:4]};
    assign conv_stop = (r_op == OP_SHIFT) ? (r_n + 4'd1 == r_shown)
                     : ((next_mag == '0) || (r_n + 4'd1 == CNT_W'(DIGITS + 1)));

    assign too_long  = r_n > CNT_W'(DIGITS);
    assign emit_last = (r_idx + 4'd1) == r_n;
    assign out_free  = !r_out_valid || o_out.ready;
    assign new_hist  = {r_hist[NUM_W-5:0], i_in.nibble};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid && t_op'(i_in.op) != OP_CLEAR) n_state = ST_CONV;
            end
            ST_CONV: begin
                if (conv_stop) n_state = (r_neg && r_op != OP_SHIFT) ? ST_SIGN : ST_HEAD;
            end
            ST_SIGN: n_state = ST_HEAD;
            ST_HEAD: begin
                if (out_free) n_state = too_long ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free && emit_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        conv_en  = 1'b0;
        sign_en  = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: in_ready = 1'b1;
            ST_CONV: conv_en  = 1'b1;
            ST_SIGN: sign_en  = 1'b1;
            ST_HEAD: load_out = out_free;
            ST_EMIT: load_out = out_free;
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hist      <= '0;
            r_shown     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_ready && i_in.valid) begin
                unique case (t_op'(i_in.op))
                    OP_CLEAR: r_shown <= '0;
                    OP_SHIFT: begin
                        r_hist <= new_hist;
                        if (r_shown < CNT_W'(DIGITS)) r_shown <= r_shown + 4'd1;
                    end
                    default: r_shown <= r_shown;
                endcase
            end
            if (load_out) r_out_valid <= 1'b1;
            else if (r_out_valid && o_out.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_op  <= t_op'(i_in.op);
            r_n   <= '0;
            r_idx <= '0;
            if (t_op'(i_in.op) == OP_SHIFT) begin
                r_mag <= new_hist;
                r_neg <= 1'b0;
            end else begin
                r_neg <= i_in.number[NUM_W-1];
                r_mag <= i_in.number[NUM_W-1] ? NUM_W'(-i_in.number) : NUM_W'(i_in.number);
            end
        end
        if (conv_en) begin
            if (r_n < CNT_W'(DIGITS)) r_codes[r_n[IW-1:0]] <= dig_code;
            r_n   <= r_n + 4'd1;
            r_mag <= next_mag;
        end
        if (sign_en) begin
            if (r_n < CNT_W'(DIGITS)) begin
                r_codes[r_n[IW-1:0]] <= (r_op == OP_DEC) ? {4'h0, DEC_MINUS} : HEX_MINUS;
            end
            r_n <= r_n + 4'd1;
        end
        if (load_out) begin
            if (r_state == ST_HEAD) begin
                r_frame <= too_long ? '0 : {SCAN_LIMIT_ADDR, 8'(r_n - 4'd1)};
                r_last  <= too_long;
                r_err   <= too_long;
            end else begin
                r_frame <= {8'(r_idx + 4'd1), r_codes[r_idx[IW-1:0]]};
                r_last  <= emit_last;
                r_err   <= 1'b0;
                r_idx   <= r_idx + 4'd1;
            end
        end
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.frame = r_frame;
    assign o_out.last  = r_last;
    assign o_out.error = r_err;

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.error |-> o_out.last && o_out.frame == '0)
        else $error("error item not a lone zero frame");

    a_shown_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shown <= CNT_W'(DIGITS))
        else $error("shown count beyond digit count");

    a_conv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CONV |-> r_n <= CNT_W'(DIGITS))
        else $error("conversion ran past limit");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && i_in.op == OP_CLEAR |=> r_shown == '0 && r_state == ST_IDLE)
        else $error("shift count clear failed");

endmodule

>>> test/ssnf_frame_checker.sv
// Frame checker: predicts the display frames of each request and compares the frame channel.
module ssnf_frame_checker
    import ssnf_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ssnf_in_if   i_req,
    ssnf_out_if  i_frm,
    output int   o_mismatches,
    output int   o_frames_due
);

    typedef struct packed {
        logic [15:0] frame;
        logic        last;
        logic        error;
    } t_disp_frame;

    localparam logic [7:0] SEGS [16] = '{
        8'h7e, 8'h30, 8'h6d, 8'h79, 8'h33, 8'h5b, 8'h5f, 8'h70,
        8'h7f, 8'h7b, 8'h77, 8'h1f, 8'h4e, 8'h3d, 8'h4f, 8'h47
    };

    t_disp_frame frames_due [$];
    logic [31:0] nib_hist;
    logic [3:0]  shown_digits;

    task automatic predict_display_run(input t_op op, input logic [31:0] num,
                                       input logic [3:0] nib);
        logic [7:0]  digit_codes [0:11];
        int unsigned n;
        logic        neg;
        logic [31:0] mag;
        logic [31:0] t;
        t_disp_frame f;
        n   = 0;
        neg = num[31];
        mag = neg ? (32'd0 - num) : num;
        if (op == OP_CLEAR) begin
            shown_digits = '0;
            return;
        end
        if (op == OP_SHIFT) begin
            nib_hist = {nib_hist[27:0], nib};
            if (shown_digits < DIGITS)
                shown_digits = shown_digits + 1'b1;
            t = nib_hist;
            for (int i = 0; i < shown_digits; i++) begin
                digit_codes[i] = SEGS[t[3:0]];
                t = t >> 4;
            end
            n = shown_digits;
        end else if (op == OP_DEC) begin
            do begin
                digit_codes[n] = 8'(mag % 10);
                n++;
                mag = mag / 10;
            end while (mag != 0 && n < 10);
            if (neg) begin
                digit_codes[n] = {4'h0, DEC_MINUS};
                n++;
            end
        end else begin
            do begin
                digit_codes[n] = SEGS[mag[3:0]];
                n++;
                mag = mag >> 4;
            end while (mag != 0 && n < 8);
            if (neg) begin
                digit_codes[n] = HEX_MINUS;
                n++;
            end
        end
        if (n > DIGITS) begin
            f.frame = 16'h0000;
            f.last  = 1'b1;
            f.error = 1'b1;
            frames_due.push_back(f);
        end else begin
            f.frame = {SCAN_LIMIT_ADDR, 8'(n - 1)};
            f.last  = 1'b0;
            f.error = 1'b0;
            frames_due.push_back(f);
            for (int unsigned i = 0; i < n; i++) begin
                f.frame = {8'(i + 1), digit_codes[i]};
                f.last  = (i == n - 1);
                frames_due.push_back(f);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_disp_frame want;
        if (!i_rst_n) begin
            nib_hist     = '0;
            shown_digits = '0;
            frames_due.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                predict_display_run(t_op'(i_req.op), i_req.number, i_req.nibble);
            if (i_frm.valid && i_frm.ready) begin
                if (frames_due.size() == 0) begin
                    $error("frame: expected none, got %h", i_frm.frame);
                    o_mismatches++;
                end else begin
                    want = frames_due.pop_front();
                    if (i_frm.frame !== want.frame) begin
                        $error("frame: expected %h, got %h", want.frame, i_frm.frame);
                        o_mismatches++;
                    end
                    if (i_frm.last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, i_frm.last);
                        o_mismatches++;
                    end
                    if (i_frm.error !== want.error) begin
                        $error("error: expected %b, got %b", want.error, i_frm.error);
                        o_mismatches++;
                    end
                end
            end
        end
        o_frames_due <= frames_due.size();
    end

endmodule

>>> test/tb_seven_segment_number_frame_formatter.sv
// Testbench top: drives requests and frame backpressure, runs the checker and reports the verdict.
module tb_seven_segment_number_frame_formatter;
    import ssnf_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_OFF   = 400;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic hold_off_req;
    bit   send_burst;
    bit   take_burst;
    int   mismatches;
    int   frames_due;
    int   idle_cycles;

    ssnf_in_if  in_ch ();
    ssnf_out_if out_ch ();

    seven_segment_number_frame_formatter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    ssnf_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (in_ch),
        .i_frm        (out_ch),
        .o_mismatches (mismatches),
        .o_frames_due (frames_due)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_item(input t_op op, input logic [31:0] num, input logic [3:0] nib);
        int unsigned gap;
        if ($urandom_range(0, 15) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.op     <= op;
        in_ch.number <= num;
        in_ch.nibble <= nib;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    function automatic logic [31:0] rand_number();
        logic [31:0]  v;
        logic [31:0]  lim;
        int unsigned  k;
        k = $urandom_range(1, 9);
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = (k >= 8) ? $urandom : ($urandom & ((32'd1 << (4 * k)) - 1));
            2: begin
                lim = 1;
                repeat (k) lim = lim * 10;
                v = $urandom % lim;
            end
            default: v = $urandom_range(0, 20);
        endcase
        if ($urandom_range(0, 1) == 1)
            v = 32'd0 - v;
        return v;
    endfunction

    task automatic send_random(input int unsigned count);
        int unsigned r;
        repeat (count) begin
            r = $urandom_range(0, 19);
            if (r < 6)
                send_item(OP_DEC, rand_number(), 4'($urandom));
            else if (r < 11)
                send_item(OP_HEX, rand_number(), 4'($urandom));
            else if (r < 18)
                send_item(OP_SHIFT, $urandom, 4'($urandom));
            else
                send_item(OP_CLEAR, $urandom, 4'($urandom));
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        hold_off_req = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.op     = OP_DEC;
        in_ch.number = '0;
        in_ch.nibble = '0;
        out_ch.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fork
            begin
                int unsigned stall;
                forever begin
                    if (hold_off_req) begin
                        hold_off_req <= 1'b0;
                        out_ch.ready <= 1'b0;
                        repeat (HOLD_OFF) @(posedge i_clk);
                    end
                    if ($urandom_range(0, 15) == 0)
                        take_burst = !take_burst;
                    stall = take_burst ? 0 : $urandom_range(0, 19);
                    if (stall > 0) begin
                        out_ch.ready <= 1'b0;
                        repeat (stall) @(posedge i_clk);
                    end
                    out_ch.ready <= 1'b1;
                    do @(posedge i_clk); while (!out_ch.valid);
                end
            end
        join_none

        // directed: digit-count limits, sign positions, most negative value, zero
        send_item(OP_DEC, 32'd0, 4'h0);
        send_item(OP_DEC, 32'd99999999, 4'h0);
        send_item(OP_DEC, 32'd100000000, 4'h0);
        send_item(OP_DEC, 32'd0 - 32'd9999999, 4'h0);
        send_item(OP_DEC, 32'd0 - 32'd10000000, 4'h0);
        send_item(OP_DEC, 32'h7FFFFFFF, 4'h0);
        send_item(OP_DEC, 32'h80000000, 4'h0);
        send_item(OP_DEC, 32'hFFFFFFFF, 4'h0);
        send_item(OP_HEX, 32'd0, 4'h0);
        send_item(OP_HEX, 32'h7EDCBA98, 4'h0);
        send_item(OP_HEX, 32'd0 - 32'h0FFFFFFF, 4'h0);
        send_item(OP_HEX, 32'd0 - 32'h10000000, 4'h0);
        send_item(OP_HEX, 32'h80000000, 4'h0);
        send_item(OP_HEX, 32'h01234567, 4'h0);
        send_item(OP_CLEAR, 32'd0, 4'h0);
        for (int i = 8; i <= 16; i++)
            send_item(OP_SHIFT, 32'd0, 4'(i));
        send_item(OP_CLEAR, 32'd0, 4'h0);
        send_item(OP_SHIFT, 32'd0, 4'h5);

        send_random(70);

        // receiver stops for a long stretch while requests keep coming
        hold_off_req <= 1'b1;
        send_random(70);

        // drain completely before the last stretch
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (frames_due != 0) @(posedge i_clk);
        send_random(65);

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (frames_due != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && frames_due == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
